FILE: sv/elfrel_pkg.sv
package elfrel_pkg;

    localparam int BITMAP_SPAN   = 63;
    localparam int IDX_W         = $clog2(BITMAP_SPAN);
    localparam int WORD_W        = 64;
    localparam int TYPE_W        = 32;
    localparam int WORD_SHIFT    = 3;

    localparam logic [TYPE_W-1:0] RELATIVE_TYPE = TYPE_W'(1027);
    localparam logic [WORD_W-1:0] WORD_BYTES    = WORD_W'(8);
    localparam logic [WORD_W-1:0] SPAN_BYTES    = WORD_W'(BITMAP_SPAN * 8);

    localparam logic CMD_RELA = 1'b0;
    localparam logic CMD_RELR = 1'b1;

    localparam logic KIND_STORE = 1'b0;
    localparam logic KIND_ADD   = 1'b1;

    localparam logic CFG_LOAD_OFFSET = 1'b0;
    localparam logic CFG_RELR_ENABLE = 1'b1;

    typedef struct packed {
        logic                   found;
        logic [IDX_W-1:0]       idx;
        logic                   rest_empty;
        logic [BITMAP_SPAN-1:0] rest;
    } scan_t;

endpackage

FILE: sv/elfrel_relocation_stream_decoder.sv
// Relocation stream decoder.
// Input channel s_*: one relocation entry per item. s_tuser carries the
// command (0 RELA, 1 RELR); s_tdata carries entry_word, reloc_type, addend.
// Output channel m_*: one patch request per item. m_tuser is patch_kind,
// m_tlast marks the final patch of an entry, m_tdata carries address/value.
// Configuration: cfg_we with cfg_index 0 writes load_offset, 1 relr_enable.
// Sequencing: s_tready is high only while the sequencer is idle. An entry
// first passes the decode state, then:
//   RELA relative type: one patch; other types: none.
//   RELR entry while RELR is off or load_offset is 0: none.
//   RELR address entry: one patch, then a running-address step.
//   RELR bitmap entry: one patch per set bit, one a cycle while not stalled,
//   then a running-address step. All sums use the one shared 64-bit adder.
// When the receiver stalls, the output register holds its item and the
// sequencer waits before issuing the next patch; a finished result may wait
// in the output register while the next entry is taken.
// Reset clears the running address, sets load_offset to 0, relr_enable to 1
// and empties the output register.
module elf_relocation_stream_decoder (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [159:0]                        s_tdata,  // entry_word, reloc_type, addend
    input  logic [0:0]                          s_tuser,  // command
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [127:0]                        m_tdata,  // patch_address, patch_value
    output logic [0:0]                          m_tuser,  // patch_kind
    output logic                                m_tlast,  // last_of_run
    input  logic                                cfg_we,
    input  logic [0:0]                          cfg_index,
    input  logic [elfrel_pkg::WORD_W-1:0]       cfg_data
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_RELA_ADDR,
        S_RELA_EMIT,
        S_ADDR_EMIT,
        S_ADDR_STEP,
        S_BMAP,
        S_BMAP_STEP
    } state_t;

    state_t                              state_reg;
    logic [elfrel_pkg::WORD_W-1:0]       load_offset_reg;
    logic                                relr_enable_reg;
    logic [elfrel_pkg::WORD_W-1:0]       run_reg;
    logic                                cmd_reg;
    logic [elfrel_pkg::WORD_W-1:0]       word_reg;
    logic [elfrel_pkg::TYPE_W-1:0]       type_reg;
    logic [elfrel_pkg::WORD_W-1:0]       addend_reg;
    logic [elfrel_pkg::WORD_W-1:0]       addr_reg;
    logic [elfrel_pkg::BITMAP_SPAN-1:0]  mask_reg;

    logic                                out_valid_reg;
    logic [elfrel_pkg::WORD_W-1:0]       out_addr_reg;
    logic [elfrel_pkg::WORD_W-1:0]       out_value_reg;
    logic                                out_kind_reg;
    logic                                out_last_reg;

    logic [elfrel_pkg::WORD_W-1:0]       add_a;
    logic [elfrel_pkg::WORD_W-1:0]       add_b;
    logic [elfrel_pkg::WORD_W-1:0]       add_sum;
    elfrel_pkg::scan_t                   scan;
    logic                                out_free;
    logic                                emit;

    elfrel_adder u_adder (
        .a   (add_a),
        .b   (add_b),
        .sum (add_sum)
    );

    elfrel_bitscan u_bitscan (
        .mask (mask_reg),
        .scan (scan)
    );

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_value_reg, out_addr_reg};
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;
    assign out_free = !out_valid_reg || m_tready;

    always_comb
    begin
        add_a = word_reg;
        add_b = load_offset_reg;
        case (state_reg)
            S_RELA_EMIT:
            begin
                add_a = addend_reg;
                add_b = load_offset_reg;
            end
            S_ADDR_STEP:
            begin
                add_a = run_reg;
                add_b = elfrel_pkg::WORD_BYTES;
            end
            S_BMAP:
            begin
                add_a = run_reg;
                add_b = {{(elfrel_pkg::WORD_W - elfrel_pkg::IDX_W
                           - elfrel_pkg::WORD_SHIFT){1'b0}},
                         scan.idx, {elfrel_pkg::WORD_SHIFT{1'b0}}};
            end
            S_BMAP_STEP:
            begin
                add_a = run_reg;
                add_b = elfrel_pkg::SPAN_BYTES;
            end
            default:
            begin
                add_a = word_reg;
                add_b = load_offset_reg;
            end
        endcase
    end

    always_comb
    begin
        case (state_reg)
            S_RELA_EMIT: emit = out_free;
            S_ADDR_EMIT: emit = out_free;
            S_BMAP:      emit = out_free && scan.found;
            default:     emit = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            load_offset_reg <= '0;
            relr_enable_reg <= 1'b1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                elfrel_pkg::CFG_LOAD_OFFSET: load_offset_reg <= cfg_data;
                elfrel_pkg::CFG_RELR_ENABLE: relr_enable_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && s_tvalid)
        begin
            cmd_reg    <= s_tuser[0];
            word_reg   <= s_tdata[63:0];
            type_reg   <= s_tdata[95:64];
            addend_reg <= s_tdata[159:96];
        end
        if (state_reg == S_DECODE)
        begin
            mask_reg <= word_reg[elfrel_pkg::BITMAP_SPAN:1];
        end
        else if (state_reg == S_BMAP && emit)
        begin
            mask_reg <= scan.rest;
        end
        if (state_reg == S_RELA_ADDR)
        begin
            addr_reg <= add_sum;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            run_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_addr_reg  <= '0;
            out_value_reg <= '0;
            out_kind_reg  <= elfrel_pkg::KIND_STORE;
            out_last_reg  <= 1'b0;
        end
        else
        begin
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (emit)
            begin
                case (state_reg)
                    S_RELA_EMIT:
                    begin
                        out_addr_reg  <= addr_reg;
                        out_value_reg <= add_sum;
                        out_kind_reg  <= elfrel_pkg::KIND_STORE;
                        out_last_reg  <= 1'b1;
                    end
                    S_ADDR_EMIT:
                    begin
                        out_addr_reg  <= add_sum;
                        out_value_reg <= load_offset_reg;
                        out_kind_reg  <= elfrel_pkg::KIND_ADD;
                        out_last_reg  <= 1'b1;
                    end
                    default:
                    begin
                        out_addr_reg  <= add_sum;
                        out_value_reg <= load_offset_reg;
                        out_kind_reg  <= elfrel_pkg::KIND_ADD;
                        out_last_reg  <= scan.rest_empty;
                    end
                endcase
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        state_reg <= S_DECODE;
                    end
                end
                S_DECODE:
                begin
                    if (cmd_reg == elfrel_pkg::CMD_RELA)
                    begin
                        state_reg <= (type_reg == elfrel_pkg::RELATIVE_TYPE)
                                     ? S_RELA_ADDR : S_IDLE;
                    end
                    else if (relr_enable_reg && load_offset_reg != '0)
                    begin
                        state_reg <= word_reg[0] ? S_BMAP : S_ADDR_EMIT;
                    end
                    else
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_RELA_ADDR:
                begin
                    state_reg <= S_RELA_EMIT;
                end
                S_RELA_EMIT:
                begin
                    if (emit)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_ADDR_EMIT:
                begin
                    if (emit)
                    begin
                        run_reg   <= add_sum;
                        state_reg <= S_ADDR_STEP;
                    end
                end
                S_ADDR_STEP:
                begin
                    run_reg   <= add_sum;
                    state_reg <= S_IDLE;
                end
                S_BMAP:
                begin
                    if (!scan.found)
                    begin
                        state_reg <= S_BMAP_STEP;
                    end
                    else if (emit && scan.rest_empty)
                    begin
                        state_reg <= S_BMAP_STEP;
                    end
                end
                S_BMAP_STEP:
                begin
                    run_reg   <= add_sum;
                    state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    a_bmap_one_bit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_BMAP && emit) |=>
        ($countones(mask_reg) == $countones($past(mask_reg)) - 1))
        else $error("bitmap patch did not retire exactly one bit");

    a_bmap_step_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_BMAP_STEP) |-> (mask_reg == '0))
        else $error("running address advanced with bitmap bits pending");

    a_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && ((state_reg != S_BMAP) || scan.rest_empty)) |=>
        (state_reg == S_IDLE || state_reg == S_ADDR_STEP || state_reg == S_BMAP_STEP))
        else $error("sequencer kept issuing after the final patch");

    a_emit_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !m_tready) |-> !emit)
        else $error("patch issued into an occupied output register");
`endif

endmodule

FILE: sv/elfrel_adder.sv
module elfrel_adder (
    input  logic [elfrel_pkg::WORD_W-1:0] a,
    input  logic [elfrel_pkg::WORD_W-1:0] b,
    output logic [elfrel_pkg::WORD_W-1:0] sum
);

    assign sum = a + b;

endmodule

FILE: sv/elfrel_bitscan.sv
module elfrel_bitscan (
    input  logic [elfrel_pkg::BITMAP_SPAN-1:0] mask,
    output elfrel_pkg::scan_t                  scan
);

    logic [elfrel_pkg::BITMAP_SPAN-1:0] rest;

    // clear lowest set bit
    assign rest = mask & (mask - elfrel_pkg::BITMAP_SPAN'(1));

    always_comb
    begin
        scan.idx = '0;
        for (int k = elfrel_pkg::BITMAP_SPAN - 1; k >= 0; k--)
        begin
            if (mask[k])
            begin
                scan.idx = elfrel_pkg::IDX_W'(k);
            end
        end
        scan.found      = (mask != '0);
        scan.rest       = rest;
        scan.rest_empty = (rest == '0);
    end

endmodule
